>>> hdl/gn3d_pkg.sv
// Shared constants and types for the 3D gradient noise block.
// Used by the front end, the queue, the back end and the top level.
`default_nettype none

package gn3d_pkg;

	localparam int FRAC_W     = 16;
	localparam int TABLE_SIZE = 256;
	localparam int IDX_W      = $clog2(TABLE_SIZE);
	localparam int PERM_W     = 8;
	localparam int GRAD_W     = 16;
	localparam int POINT_W    = 32;
	localparam int OUT_W      = 20;
	localparam int IN_DATA_W  = 176;
	localparam int OUT_DATA_W = 24;
	localparam int CORNER_W   = 3;
	localparam int QUEUE_DEPTH = 4;

	// Command codes carried on tuser.
	localparam logic CMD_LOAD = 1'b0;
	localparam logic CMD_EVAL = 1'b1;

	// One classified command as it waits between front and back end.
	typedef struct packed {
		logic                            cmd;
		logic [PERM_W-1:0]               index;
		logic [2:0][PERM_W-1:0]          perm;
		logic [2:0][GRAD_W-1:0]          grad;
		logic [2:0][IDX_W-1:0]           lat;
		logic [2:0][FRAC_W-1:0]          frac;
		logic [2:0][FRAC_W-1:0]          smooth;
	} entry_t;

endpackage

`default_nettype wire

>>> hdl/gradient_noise_3d.sv
// Top level of the 3D gradient noise block: front end, command queue, back end.
// Depends on gn3d_pkg, gn3d_front, gn3d_queue and gn3d_back.
//
// Streams commands in and noise samples out. tuser 0 loads one table entry
// (permutation values and gradient at entry_index) and gives no output;
// tuser 1 evaluates Perlin noise at a Q16.16 point and gives one Q3.16
// sample, saturated to 20 bits. Input transfers pass a two-stage front end
// that forms lattice indices, fractions and Hermite weights, then wait in a
// four-entry queue. In the back end a load writes its table entry as it
// leaves the queue. An evaluate leaves the queue, then the eight lattice
// corners are issued one per cycle, since each needs its own read of the
// single-port permutation and gradient tables, and each corner then passes
// through the dot product, weight and accumulate pipeline. An evaluate
// leaves the queue only once the output register is free. The front end
// keeps accepting while the back end works and while a sample waits on the
// output, until the queue is full and the second front stage holds a command.
`default_nettype none

module gradient_noise_3d (
	input  wire                                clk,
	input  wire                                arst_n,
	input  wire                                s_tvalid,
	output logic                               s_tready,
	// entry_index, perm_x_value, perm_y_value, perm_z_value, grad_x, grad_y,
	// grad_z, point_x, point_y, point_z
	input  wire  [gn3d_pkg::IN_DATA_W-1:0]     s_tdata,
	// command
	input  wire                                s_tuser,
	output logic                               m_tvalid,
	input  wire                                m_tready,
	// noise_value, zero filled
	output logic [gn3d_pkg::OUT_DATA_W-1:0]    m_tdata
);

	logic                          fq_valid, fq_ready, qb_valid, qb_ready;
	gn3d_pkg::entry_t              fq_entry, qb_entry;
	logic [gn3d_pkg::OUT_W-1:0]    noise_value;

	assign m_tdata = gn3d_pkg::OUT_DATA_W'(noise_value);

	gn3d_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.q_valid  (fq_valid),
		.q_ready  (fq_ready),
		.q_entry  (fq_entry)
	);

	gn3d_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (fq_valid),
		.in_ready  (fq_ready),
		.in_entry  (fq_entry),
		.out_valid (qb_valid),
		.out_ready (qb_ready),
		.out_entry (qb_entry)
	);

	gn3d_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_valid     (qb_valid),
		.q_ready     (qb_ready),
		.q_entry     (qb_entry),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.noise_value (noise_value)
	);

endmodule

`default_nettype wire

>>> hdl/gn3d_front.sv
// Front end: accepts stream transfers, splits the point into lattice index and
// fraction and computes the Hermite weights in two stages. Uses gn3d_pkg.
`default_nettype none

module gn3d_front (
	input  wire                                  clk,
	input  wire                                  arst_n,
	input  wire                                  s_tvalid,
	output logic                                 s_tready,
	input  wire  [gn3d_pkg::IN_DATA_W-1:0]       s_tdata,
	input  wire                                  s_tuser,
	output logic                                 q_valid,
	input  wire                                  q_ready,
	output gn3d_pkg::entry_t                     q_entry
);

	localparam int F = gn3d_pkg::FRAC_W;

	logic                       v_s1, v_s2;
	gn3d_pkg::entry_t           ent_s1, ent_s2, ent_in, ent_mid;
	logic [2:0][F-1:0]          t2_s1, t2_in;
	logic [2:0][F-1:0]          smooth_new;
	logic                       adv;

	// All stages move together whenever the last one can drain.
	assign adv      = !v_s2 || q_ready;
	assign s_tready = adv;
	assign q_valid  = v_s2;
	assign q_entry  = ent_s2;

	// Unpack the transfer and square each fraction.
	always_comb begin
		logic [gn3d_pkg::POINT_W-1:0] p;
		logic [2*F-1:0]               sq;
		ent_in        = '0;
		ent_in.cmd    = s_tuser;
		ent_in.index  = s_tdata[7:0];
		ent_in.perm[0] = s_tdata[15:8];
		ent_in.perm[1] = s_tdata[23:16];
		ent_in.perm[2] = s_tdata[31:24];
		ent_in.grad[0] = s_tdata[47:32];
		ent_in.grad[1] = s_tdata[63:48];
		ent_in.grad[2] = s_tdata[79:64];
		for (int a = 0; a < 3; a++) begin
			p  = s_tdata[80 + a*gn3d_pkg::POINT_W +: gn3d_pkg::POINT_W];
			ent_in.frac[a] = p[F-1:0];
			// Two's complement bits above the fraction give the floored index mod table size.
			ent_in.lat[a]  = p[F +: gn3d_pkg::IDX_W];
			sq       = p[F-1:0] * p[F-1:0];
			t2_in[a] = sq[2*F-1:F];
		end
	end

	// Smooth weight s = t2 * (3 - 2t), truncated back to the fraction grid.
	always_comb begin
		logic [F+1:0]   k;
		logic [2*F+1:0] m;
		for (int a = 0; a < 3; a++) begin
			k = (F+2)'(3) << F;
			k = k - {1'b0, ent_s1.frac[a], 1'b0};
			m = t2_s1[a] * k;
			smooth_new[a] = m[2*F-1:F];
		end
		ent_mid        = ent_s1;
		ent_mid.smooth = smooth_new;
	end

	// Valid bits of the two stages.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s1 <= s_tvalid;
			v_s2 <= v_s1;
		end
	end

	// Payload of the two stages.
	always_ff @(posedge clk) begin
		if (adv) begin
			ent_s1 <= ent_in;
			t2_s1  <= t2_in;
			ent_s2 <= ent_mid;
		end
	end

endmodule

`default_nettype wire

>>> hdl/gn3d_queue.sv
// Short queue of classified commands between front and back end.
// Uses gn3d_pkg for the entry type and depth.
`default_nettype none

module gn3d_queue (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               in_valid,
	output logic              in_ready,
	input  gn3d_pkg::entry_t  in_entry,
	output logic              out_valid,
	input  wire               out_ready,
	output gn3d_pkg::entry_t  out_entry
);

	localparam int DEPTH = gn3d_pkg::QUEUE_DEPTH;
	localparam int PTR_W = $clog2(DEPTH);

	gn3d_pkg::entry_t    store_q [DEPTH];
	logic [PTR_W-1:0]    wr_ptr_q, rd_ptr_q;
	logic [PTR_W:0]      count_q;
	logic                push, pop;

	assign in_ready  = count_q != (PTR_W+1)'(DEPTH);
	assign out_valid = count_q != '0;
	assign out_entry = store_q[rd_ptr_q];
	assign push      = in_valid && in_ready;
	assign pop       = out_valid && out_ready;

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !pop)      count_q <= count_q + 1'b1;
			else if (pop && !push) count_q <= count_q - 1'b1;
		end
	end

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) store_q[wr_ptr_q] <= in_entry;
	end

endmodule

`default_nettype wire

>>> hdl/gn3d_back.sv
// Back end: permutation and gradient tables, corner sequencer, dot product
// and blend pipeline, and the output register. Uses gn3d_pkg.
`default_nettype none

module gn3d_back (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              q_valid,
	output logic                             q_ready,
	input  gn3d_pkg::entry_t                 q_entry,
	output logic                             m_tvalid,
	input  wire                              m_tready,
	output logic [gn3d_pkg::OUT_W-1:0]       noise_value
);

	localparam int F     = gn3d_pkg::FRAC_W;
	localparam int IW    = gn3d_pkg::IDX_W;
	localparam int PW    = gn3d_pkg::PERM_W;
	localparam int GW    = gn3d_pkg::GRAD_W;
	localparam int CW    = gn3d_pkg::CORNER_W;
	localparam int OW    = gn3d_pkg::OUT_W;
	localparam int WW    = F + 1;           // weight, up to one
	localparam int PRW   = GW + F + 1;      // gradient times offset
	localparam int SW    = PRW + 2;         // sum of three products
	localparam int DW    = SW - (F - 1);    // dot product on the Q.16 grid
	localparam int MW    = WW + 1 + DW;     // weight times dot
	localparam int AW    = MW + CW;         // accumulator over eight corners
	localparam int SHW   = AW - F;
	localparam logic [WW-1:0] ONE = WW'(1) << F;
	localparam logic [CW-1:0] LAST_CORNER = '1;
	localparam logic signed [SHW-1:0] SAT_MAX = SHW'((1 << (OW-1)) - 1);
	localparam logic signed [SHW-1:0] SAT_MIN = -SHW'(1 << (OW-1));

	// Tables.
	logic [PW-1:0]       perm_x_mem [gn3d_pkg::TABLE_SIZE];
	logic [PW-1:0]       perm_y_mem [gn3d_pkg::TABLE_SIZE];
	logic [PW-1:0]       perm_z_mem [gn3d_pkg::TABLE_SIZE];
	logic [3*GW-1:0]     grad_mem   [gn3d_pkg::TABLE_SIZE];

	// Sequencer and operands of the command in progress.
	logic                issuing_q;
	logic [CW-1:0]       cnt_q;
	logic [2:0][IW-1:0]  lat_q;
	logic [2:0][F-1:0]   frac_q, smooth_q;

	// Corner pipeline.
	logic                v_p1, v_p2, v_p3, v_p4, v_p5;
	logic [CW-1:0]       c_p1, c_p2, c_p3, c_p4, c_p5;
	logic [PW-1:0]       px_p1, py_p1, pz_p1;
	logic [3*GW-1:0]     grad_p2;
	logic [WW-1:0]       wxy_p2, w_p3, w_p4;
	logic signed [PRW-1:0] gox_p3, goy_p3, goz_p3;
	logic signed [DW-1:0]  d16_p4;
	logic signed [MW-1:0]  prod_p5;
	logic signed [AW-1:0]  acc_q;

	logic                out_valid_q;
	logic [OW-1:0]       out_q;

	logic                busy, out_free, pop_load, pop_eval, fin;
	logic [IW-1:0]       addr_x, addr_y, addr_z, grad_addr;
	logic [WW-1:0]       wx, wy, wz;
	logic [2*WW-1:0]     wxy_full, w_full;
	logic signed [F:0]   ox, oy, oz;
	logic signed [SW-1:0]  dot_sum;
	logic signed [AW-1:0]  acc_next;
	logic signed [SHW-1:0] acc_sh;
	logic [OW-1:0]       sat_val;

	// Command dispatch from the queue.
	assign busy     = issuing_q || v_p1 || v_p2 || v_p3 || v_p4 || v_p5;
	assign out_free = !out_valid_q || m_tready;
	assign q_ready  = !busy && (q_entry.cmd == gn3d_pkg::CMD_LOAD || out_free);
	assign pop_load = q_valid && q_ready && q_entry.cmd == gn3d_pkg::CMD_LOAD;
	assign pop_eval = q_valid && q_ready && q_entry.cmd == gn3d_pkg::CMD_EVAL;
	assign fin      = v_p5 && c_p5 == LAST_CORNER;

	assign m_tvalid    = out_valid_q;
	assign noise_value = out_q;

	// Corner addresses: the high cell on an axis is one step further, wrapped.
	assign addr_x    = lat_q[0] + IW'(cnt_q[2]);
	assign addr_y    = lat_q[1] + IW'(cnt_q[1]);
	assign addr_z    = lat_q[2] + IW'(cnt_q[0]);
	assign grad_addr = IW'(px_p1 ^ py_p1 ^ pz_p1);

	// Axis weights and offsets for the corner in each stage.
	always_comb begin
		wx = c_p1[2] ? WW'(smooth_q[0]) : ONE - WW'(smooth_q[0]);
		wy = c_p1[1] ? WW'(smooth_q[1]) : ONE - WW'(smooth_q[1]);
		wz = c_p2[0] ? WW'(smooth_q[2]) : ONE - WW'(smooth_q[2]);
		wxy_full = wx * wy;
		w_full   = wxy_p2 * wz;
		ox = $signed({1'b0, frac_q[0]}) - (c_p2[2] ? $signed(ONE) : $signed(WW'(0)));
		oy = $signed({1'b0, frac_q[1]}) - (c_p2[1] ? $signed(ONE) : $signed(WW'(0)));
		oz = $signed({1'b0, frac_q[2]}) - (c_p2[0] ? $signed(ONE) : $signed(WW'(0)));
		dot_sum  = SW'(gox_p3) + SW'(goy_p3) + SW'(goz_p3);
		acc_next = acc_q + AW'(prod_p5);
		acc_sh   = acc_next[AW-1:F];
		if (acc_sh > SAT_MAX)      sat_val = SAT_MAX[OW-1:0];
		else if (acc_sh < SAT_MIN) sat_val = SAT_MIN[OW-1:0];
		else                       sat_val = acc_sh[OW-1:0];
	end

	// Control: sequencer, stage valid bits and output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			issuing_q   <= 1'b0;
			cnt_q       <= '0;
			v_p1        <= 1'b0;
			v_p2        <= 1'b0;
			v_p3        <= 1'b0;
			v_p4        <= 1'b0;
			v_p5        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop_eval) begin
				issuing_q <= 1'b1;
				cnt_q     <= '0;
			end else if (issuing_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == LAST_CORNER) issuing_q <= 1'b0;
			end
			v_p1 <= issuing_q;
			v_p2 <= v_p1;
			v_p3 <= v_p2;
			v_p4 <= v_p3;
			v_p5 <= v_p4;
			if (fin)           out_valid_q <= 1'b1;
			else if (m_tready) out_valid_q <= 1'b0;
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		if (pop_eval) begin
			lat_q    <= q_entry.lat;
			frac_q   <= q_entry.frac;
			smooth_q <= q_entry.smooth;
			acc_q    <= '0;
		end else if (v_p5) begin
			acc_q <= acc_next;
		end
		c_p1 <= cnt_q;
		c_p2 <= c_p1;
		c_p3 <= c_p2;
		c_p4 <= c_p3;
		c_p5 <= c_p4;
		wxy_p2 <= wxy_full[2*F:F];
		gox_p3 <= $signed(grad_p2[0*GW +: GW]) * ox;
		goy_p3 <= $signed(grad_p2[1*GW +: GW]) * oy;
		goz_p3 <= $signed(grad_p2[2*GW +: GW]) * oz;
		w_p3   <= w_full[2*F:F];
		d16_p4 <= dot_sum[SW-1:F-1];
		w_p4   <= w_p3;
		prod_p5 <= $signed({1'b0, w_p4}) * d16_p4;
		if (fin) out_q <= sat_val;
	end

	// Permutation tables: written by loads, read once per corner.
	always_ff @(posedge clk) begin
		if (pop_load && 32'(q_entry.index) < gn3d_pkg::TABLE_SIZE) begin
			perm_x_mem[IW'(q_entry.index)] <= q_entry.perm[0];
			perm_y_mem[IW'(q_entry.index)] <= q_entry.perm[1];
			perm_z_mem[IW'(q_entry.index)] <= q_entry.perm[2];
		end
		if (issuing_q) begin
			px_p1 <= perm_x_mem[addr_x];
			py_p1 <= perm_y_mem[addr_y];
			pz_p1 <= perm_z_mem[addr_z];
		end
	end

	// Gradient table.
	always_ff @(posedge clk) begin
		if (pop_load && 32'(q_entry.index) < gn3d_pkg::TABLE_SIZE) begin
			grad_mem[IW'(q_entry.index)] <= q_entry.grad;
		end
		if (v_p1) grad_p2 <= grad_mem[grad_addr];
	end

	// A finished result always finds the output register empty.
	a_fin_slot: assert property (@(posedge clk) disable iff (!arst_n)
		fin |-> !out_valid_q) else $error("result overwrote pending output");

	// No command leaves the queue while corners are in flight.
	a_no_pop_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(pop_load || pop_eval) |-> !busy) else $error("dispatch while busy");

	// The sequencer stops after the last corner.
	a_eight_corners: assert property (@(posedge clk) disable iff (!arst_n)
		(issuing_q && cnt_q == LAST_CORNER) |=> !issuing_q)
		else $error("corner sequencer overran");

	// The last corner leaving the pipeline was issued by the sequencer and passed every corner stage.
	a_last_issued: assert property (@(posedge clk) disable iff (!arst_n)
		fin |-> $past(issuing_q, 5)) else $error("stray final corner");

endmodule

`default_nettype wire
